### design/indexed_min_heap_timer_assert.svh
// Assertion macros shared by the indexed min-heap timer.
`ifndef INDEXED_MIN_HEAP_TIMER_ASSERT_SVH
`define INDEXED_MIN_HEAP_TIMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IMHT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IMHT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/imht_pkg.sv
// Shared types, codes and defaults of the indexed min-heap timer.
package imht_pkg;

    localparam int ID_W         = 10;
    localparam int CAPACITY_DEF = 64;
    localparam int ID_SPACE_DEF = 1024;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_ADJUST = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] timer_id;
        logic [31:0]     now;
        logic [30:0]     timeout;
    } in_req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic            earliest_valid;
        logic [ID_W-1:0] earliest_id;
        logic [31:0]     earliest_deadline;
        logic [6:0]      entry_count;
    } result_t;

    // Commands from controller to datapath, one per cycle.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_FULL,
        CMD_ABSENT,
        CMD_INSERT,
        CMD_REARM,
        CMD_REMOVE,
        CMD_TAKE_LAST,
        CMD_RD_LEFT,
        CMD_RD_RIGHT,
        CMD_DN_STEP,
        CMD_RD_PARENT,
        CMD_UP_STEP,
        CMD_PLACE,
        CMD_RD_ROOT,
        CMD_OUTPUT
    } dp_cmd_t;

    // Status flags from datapath to controller.
    typedef struct packed {
        logic       clr_last;
        logic       id_ok;
        logic       present;
        logic       full;
        logic       rm_tail;
        logic       has_left;
        logic       dn_move;
        logic       moved_down;
        logic       at_root;
        logic       up_move;
        logic       out_busy;
        logic [1:0] op;
    } dp_stat_t;

endpackage

### design/indexed_min_heap_timer.sv
// Top level of the indexed min-heap timer: controller, datapath and checks.
// One request at a time: lookup of the id map is a read and then a check, each
// sift-down level is a left read, a right read and a compare and move, and each
// sift-up level a parent read and a compare and move, followed by a placement
// write, a root read and the output load; a removal that does not take the last
// slot first refills the vacated slot from the tail. The heap memory has a single
// read port, so the children and the parent are read one at a time. A result waits
// in the output register while the next request is taken. After reset the id map
// is swept clear, one entry a cycle over all ID_SPACE entries (1024 by default),
// before the first request is accepted.
module indexed_min_heap_timer #(
    parameter int CAPACITY  = imht_pkg::CAPACITY_DEF,
    parameter int ID_SPACE  = imht_pkg::ID_SPACE_DEF,
    parameter int TIME_BITS = imht_pkg::TIME_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  imht_pkg::in_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output imht_pkg::result_t m_data
);
    import imht_pkg::*;

    `include "indexed_min_heap_timer_assert.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    imht_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .cmd(cmd)
    );

    imht_dp #(.CAPACITY(CAPACITY), .ID_SPACE(ID_SPACE), .TIME_BITS(TIME_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data), .m_ready(m_ready),
        .m_valid(m_valid), .m_data(m_data), .cmd(cmd), .stat(stat)
    );

    // Checks
    `IMHT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready,
        "request taken while busy")
    `IMHT_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_valid && !m_data.earliest_valid,
        m_data.earliest_id == '0 && m_data.earliest_deadline == '0,
        "empty heap reports a timer")
    `IMHT_ASSERT_NOW(a_full_count, aclk, aresetn, m_valid && m_data.status == ST_FULL,
        m_data.entry_count == 7'(CAPACITY), "full status with spare room")
    `IMHT_ASSERT_NOW(a_valid_count, aclk, aresetn, m_valid,
        m_data.earliest_valid == (m_data.entry_count != '0),
        "earliest flag disagrees with count")
endmodule

### design/imht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### design/imht_ctrl.sv
// Sequencer of the indexed min-heap timer: lookup, sift-down, sift-up, output.
module imht_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  imht_pkg::dp_stat_t stat,
    output imht_pkg::dp_cmd_t  cmd
);
    import imht_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_TAIL, S_DN_L, S_DN_R, S_DN_C,
        S_UP_R, S_UP_C, S_PLACE, S_ROOT, S_OUT
    } state_t;

    state_t state_reg, state_next;

    // Next state and command for this cycle
    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_CLEAR: begin
                cmd = CMD_CLEAR;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                state_next = S_ROOT;
                if (stat.op == OP_ADD || stat.op == OP_ADJUST || stat.op == OP_REMOVE) begin
                    if (!stat.id_ok) begin
                        cmd = CMD_ABSENT;
                    end else if (stat.op == OP_ADD) begin
                        if (stat.present) begin
                            cmd        = CMD_REARM;
                            state_next = S_DN_L;
                        end else if (stat.full) begin
                            cmd = CMD_FULL;
                        end else begin
                            cmd        = CMD_INSERT;
                            state_next = S_UP_R;
                        end
                    end else if (!stat.present) begin
                        cmd = CMD_ABSENT;
                    end else if (stat.op == OP_ADJUST) begin
                        cmd        = CMD_REARM;
                        state_next = S_DN_L;
                    end else begin
                        cmd        = CMD_REMOVE;
                        state_next = stat.rm_tail ? S_ROOT : S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                cmd        = CMD_TAKE_LAST;
                state_next = S_DN_L;
            end
            S_DN_L: begin
                if (stat.has_left) begin
                    cmd        = CMD_RD_LEFT;
                    state_next = S_DN_R;
                end else begin
                    state_next = stat.moved_down ? S_PLACE : S_UP_R;
                end
            end
            S_DN_R: begin
                cmd        = CMD_RD_RIGHT;
                state_next = S_DN_C;
            end
            S_DN_C: begin
                if (stat.dn_move) begin
                    cmd        = CMD_DN_STEP;
                    state_next = S_DN_L;
                end else begin
                    state_next = stat.moved_down ? S_PLACE : S_UP_R;
                end
            end
            S_UP_R: begin
                if (stat.at_root) begin
                    state_next = S_PLACE;
                end else begin
                    cmd        = CMD_RD_PARENT;
                    state_next = S_UP_C;
                end
            end
            S_UP_C: begin
                if (stat.up_move) begin
                    cmd        = CMD_UP_STEP;
                    state_next = S_UP_R;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                cmd        = CMD_PLACE;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                cmd        = CMD_RD_ROOT;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd        = CMD_OUTPUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
endmodule

### design/imht_dp.sv
// Datapath of the indexed min-heap timer: heap and id map memories, sift registers.
module imht_dp #(
    parameter int CAPACITY  = imht_pkg::CAPACITY_DEF,
    parameter int ID_SPACE  = imht_pkg::ID_SPACE_DEF,
    parameter int TIME_BITS = imht_pkg::TIME_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  imht_pkg::in_req_t  s_data,
    input  logic               m_ready,
    output logic               m_valid,
    output imht_pkg::result_t  m_data,
    input  imht_pkg::dp_cmd_t  cmd,
    output imht_pkg::dp_stat_t stat
);
    import imht_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = SLOT_W + 2;
    localparam int MAP_AW = $clog2(ID_SPACE);
    localparam int HW     = ID_W + TIME_BITS;
    localparam int NW     = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

    // Memories
    logic              heap_we, heap_re;
    logic [SLOT_W-1:0] heap_waddr, heap_raddr;
    logic [HW-1:0]     heap_wdata, heap_rd;
    logic              map_we, map_re;
    logic [MAP_AW-1:0] map_waddr, map_raddr;
    logic [SLOT_W:0]   map_wdata, map_rd;

    imht_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
        .aclk(aclk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .re(heap_re), .raddr(heap_raddr), .rdata(heap_rd)
    );

    imht_ram #(.WIDTH(SLOT_W + 1), .DEPTH(ID_SPACE)) u_map (
        .aclk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .re(map_re), .raddr(map_raddr), .rdata(map_rd)
    );

    // Registers
    in_req_t             req_reg;
    logic [TIME_BITS-1:0] dl_reg;
    logic [1:0]          status_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    lim_reg;
    logic [SLOT_W-1:0]   pos_reg, start_reg, kid_reg;
    logic [ID_W-1:0]     ent_id_reg, lch_id_reg;
    logic [TIME_BITS-1:0] ent_dl_reg, lch_dl_reg;
    logic [MAP_AW-1:0]   clr_reg;
    logic                m_valid_reg;
    result_t             out_reg;

    // Deadline: now plus timeout, saturating at the all-ones time
    logic [NW-1:0]        tmax_w, dl_sum;
    logic [TIME_BITS-1:0] dl_calc;
    assign tmax_w  = (NW'(1) << TIME_BITS) - NW'(1);
    assign dl_sum  = (NW'(s_data.now) & tmax_w) + NW'(s_data.timeout);
    assign dl_calc = (dl_sum > tmax_w) ? TIME_BITS'(tmax_w) : TIME_BITS'(dl_sum);

    // Field views and index arithmetic
    logic [ID_W-1:0]      rd_id, ch_id;
    logic [TIME_BITS-1:0] rd_dl, ch_dl;
    logic [SLOT_W-1:0]    map_slot, ch_idx, parent_idx;
    logic [IDX_W-1:0]     left_idx, right_idx;
    logic                 right_ok, use_right;
    logic [MAP_AW-1:0]    id_addr;

    assign rd_id      = heap_rd[HW-1 -: ID_W];
    assign rd_dl      = heap_rd[TIME_BITS-1:0];
    assign map_slot   = map_rd[SLOT_W-1:0];
    assign id_addr    = MAP_AW'(req_reg.timer_id);
    assign left_idx   = (IDX_W'(pos_reg) << 1) + IDX_W'(1);
    assign right_idx  = IDX_W'(kid_reg) + IDX_W'(1);
    assign parent_idx = SLOT_W'((pos_reg - SLOT_W'(1)) >> 1);
    assign right_ok   = right_idx < IDX_W'(lim_reg);
    assign use_right  = right_ok && (rd_dl < lch_dl_reg);
    assign ch_id      = use_right ? rd_id : lch_id_reg;
    assign ch_dl      = use_right ? rd_dl : lch_dl_reg;
    assign ch_idx     = use_right ? SLOT_W'(right_idx) : kid_reg;

    // Status to controller
    always_comb begin
        stat.clr_last   = (32'(clr_reg) == ID_SPACE - 1);
        stat.id_ok      = (32'(req_reg.timer_id) < ID_SPACE);
        stat.present    = map_rd[SLOT_W];
        stat.full       = (32'(count_reg) == CAPACITY);
        stat.rm_tail    = (CNT_W'(map_slot) == count_reg - CNT_W'(1));
        stat.has_left   = left_idx < IDX_W'(lim_reg);
        stat.dn_move    = ent_dl_reg > ch_dl;
        stat.moved_down = (pos_reg != start_reg);
        stat.at_root    = (pos_reg == '0);
        stat.up_move    = rd_dl > ent_dl_reg;
        stat.out_busy   = m_valid_reg && !m_ready;
        stat.op         = req_reg.operation;
    end

    // Memory port steering
    always_comb begin
        heap_we    = 1'b0;
        heap_waddr = pos_reg;
        heap_wdata = {ent_id_reg, ent_dl_reg};
        heap_re    = 1'b0;
        heap_raddr = '0;
        map_we     = 1'b0;
        map_waddr  = id_addr;
        map_wdata  = '0;
        map_re     = 1'b0;
        map_raddr  = MAP_AW'(s_data.timer_id);
        case (cmd)
            CMD_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
            end
            CMD_LOAD: map_re = 1'b1;
            CMD_INSERT: begin
                map_we    = 1'b1;
                map_wdata = {1'b1, SLOT_W'(count_reg)};
            end
            CMD_REMOVE: begin
                map_we     = 1'b1;
                heap_re    = 1'b1;
                heap_raddr = SLOT_W'(count_reg - CNT_W'(1));
            end
            CMD_RD_LEFT: begin
                heap_re    = 1'b1;
                heap_raddr = SLOT_W'(left_idx);
            end
            CMD_RD_RIGHT: begin
                heap_re    = right_ok;
                heap_raddr = SLOT_W'(right_idx);
            end
            CMD_DN_STEP: begin
                heap_we    = 1'b1;
                heap_wdata = {ch_id, ch_dl};
                map_we     = 1'b1;
                map_waddr  = MAP_AW'(ch_id);
                map_wdata  = {1'b1, pos_reg};
            end
            CMD_RD_PARENT: begin
                heap_re    = 1'b1;
                heap_raddr = parent_idx;
            end
            CMD_UP_STEP: begin
                heap_we    = 1'b1;
                heap_wdata = heap_rd;
                map_we     = 1'b1;
                map_waddr  = MAP_AW'(rd_id);
                map_wdata  = {1'b1, pos_reg};
            end
            CMD_PLACE: begin
                heap_we   = 1'b1;
                map_we    = 1'b1;
                map_waddr = MAP_AW'(ent_id_reg);
                map_wdata = {1'b1, pos_reg};
            end
            CMD_RD_ROOT: heap_re = 1'b1;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd == CMD_CLEAR) clr_reg <= clr_reg + MAP_AW'(1);
            if (cmd == CMD_INSERT) count_reg <= count_reg + CNT_W'(1);
            if (cmd == CMD_REMOVE) count_reg <= count_reg - CNT_W'(1);
            if (cmd == CMD_OUTPUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_LOAD: begin
                req_reg    <= s_data;
                dl_reg     <= dl_calc;
                status_reg <= ST_OK;
            end
            CMD_FULL:   status_reg <= ST_FULL;
            CMD_ABSENT: status_reg <= ST_ABSENT;
            CMD_INSERT: begin
                pos_reg    <= SLOT_W'(count_reg);
                start_reg  <= SLOT_W'(count_reg);
                ent_id_reg <= req_reg.timer_id;
                ent_dl_reg <= dl_reg;
            end
            CMD_REARM: begin
                pos_reg    <= map_slot;
                start_reg  <= map_slot;
                ent_id_reg <= req_reg.timer_id;
                ent_dl_reg <= dl_reg;
                lim_reg    <= count_reg;
            end
            CMD_REMOVE: begin
                pos_reg   <= map_slot;
                start_reg <= map_slot;
                lim_reg   <= count_reg - CNT_W'(1);
            end
            CMD_TAKE_LAST: begin
                ent_id_reg <= rd_id;
                ent_dl_reg <= rd_dl;
            end
            CMD_RD_LEFT:   kid_reg <= SLOT_W'(left_idx);
            CMD_RD_RIGHT: begin
                lch_id_reg <= rd_id;
                lch_dl_reg <= rd_dl;
            end
            CMD_DN_STEP:   pos_reg <= ch_idx;
            CMD_RD_PARENT: kid_reg <= parent_idx;
            CMD_UP_STEP:   pos_reg <= kid_reg;
            CMD_OUTPUT: begin
                out_reg.status            <= status_reg;
                out_reg.earliest_valid    <= (count_reg != '0);
                out_reg.earliest_id       <= (count_reg != '0) ? rd_id : '0;
                out_reg.earliest_deadline <= (count_reg != '0) ? 32'(rd_dl) : 32'd0;
                out_reg.entry_count       <= 7'(count_reg);
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
endmodule

### bench/tb_indexed_min_heap_timer.sv
// Self-checking bench for the indexed min-heap timer: queued stimulus, heap predictor, checks.
module tb_indexed_min_heap_timer;
    import imht_pkg::*;

    localparam int CAP      = 64;
    localparam int IDS      = 1024;
    localparam int LIMIT    = 400000;
    localparam int HOLD_LEN = 300;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    in_req_t s_data;
    logic    m_valid;
    logic    m_ready;
    result_t m_data;

    indexed_min_heap_timer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Clock
    always begin
        aclk = 1'b0; #1;
        aclk = 1'b1; #1;
    end

    // Timer heap shadow state
    logic [ID_W-1:0] shadow_id [CAP];
    logic [31:0]     shadow_dl [CAP];
    bit              id_held   [IDS];
    int              id_slot   [IDS];
    int              held;

    in_req_t pending_reqs[$];
    result_t expected_results[$];
    int      errors;
    int      cycles;
    bit      calm;          // no idling in the last part
    bit      pause_sender;
    bit      hold_start;    // asks for the long receiver hold-off
    bit      hold_done;
    int      hold_rx;       // long receiver hold-off, in cycles

    // Live id set for well-formed stimulus
    int      live_ids[$];

    function automatic void queue_req(input in_req_t rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endfunction

    function automatic void swap_slots(input int a, input int b);
        logic [ID_W-1:0] ti;
        logic [31:0]     td;
        ti = shadow_id[a]; td = shadow_dl[a];
        shadow_id[a] = shadow_id[b]; shadow_dl[a] = shadow_dl[b];
        shadow_id[b] = ti; shadow_dl[b] = td;
        id_slot[shadow_id[a]] = a;
        id_slot[shadow_id[b]] = b;
    endfunction

    function automatic void bubble_up(input int p);
        int up;
        while (p > 0) begin
            up = (p - 1) / 2;
            if (shadow_dl[up] > shadow_dl[p]) begin
                swap_slots(p, up);
                p = up;
            end else break;
        end
    endfunction

    function automatic bit bubble_down(input int p, input int n);
        int st;
        int kid;
        st = p;
        kid = 2 * p + 1;
        while (kid < n) begin
            if (kid + 1 < n && shadow_dl[kid + 1] < shadow_dl[kid]) kid++;
            if (shadow_dl[p] <= shadow_dl[kid]) break;
            swap_slots(p, kid);
            p = kid;
            kid = 2 * p + 1;
        end
        return p > st;
    endfunction

    function automatic void reorder_at(input int p, input int n);
        if (!bubble_down(p, n)) bubble_up(p);
    endfunction

    // Predict the result of one timer request
    function automatic result_t apply_timer_req(input in_req_t rq);
        result_t r;
        logic [32:0] sum;
        logic [31:0] dl;
        int p;
        int last;
        sum = {1'b0, rq.now} + {2'b0, rq.timeout};
        dl  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        r = '0;
        r.status = ST_OK;
        if (rq.operation == OP_ADD) begin
            if (id_held[rq.timer_id]) begin
                p = id_slot[rq.timer_id];
                shadow_dl[p] = dl;
                reorder_at(p, held);
            end else if (held >= CAP) begin
                r.status = ST_FULL;
            end else begin
                shadow_id[held] = rq.timer_id;
                shadow_dl[held] = dl;
                id_held[rq.timer_id] = 1'b1;
                id_slot[rq.timer_id] = held;
                held++;
                bubble_up(held - 1);
            end
        end else if (rq.operation == OP_ADJUST || rq.operation == OP_REMOVE) begin
            if (!id_held[rq.timer_id]) begin
                r.status = ST_ABSENT;
            end else if (rq.operation == OP_ADJUST) begin
                p = id_slot[rq.timer_id];
                shadow_dl[p] = dl;
                reorder_at(p, held);
            end else begin
                p = id_slot[rq.timer_id];
                last = held - 1;
                if (p < last) begin
                    swap_slots(p, last);
                    reorder_at(p, last);
                end
                id_held[rq.timer_id] = 1'b0;
                held = last;
            end
        end
        if (held > 0) begin
            r.earliest_valid    = 1'b1;
            r.earliest_id       = shadow_id[0];
            r.earliest_deadline = shadow_dl[0];
        end
        r.entry_count = 7'(held);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic in_req_t make_req(input logic [1:0] op, input int id,
                                         input logic [31:0] now, input logic [30:0] tmo);
        in_req_t rq;
        rq.operation = op;
        rq.timer_id  = ID_W'(id);
        rq.now       = now;
        rq.timeout   = tmo;
        return rq;
    endfunction

    function automatic logic [31:0] rand_now();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 50);
            1: return $urandom_range(0, 50);
            2: return $urandom;
            default: return 32'h1000 + $urandom_range(0, 4000);
        endcase
    endfunction

    function automatic logic [30:0] rand_tmo();
        case ($urandom_range(0, 5))
            0: return 31'h7FFF_FFFF;
            1: return 31'($urandom);
            2: return 31'($urandom_range(0, 3));
            default: return 31'($urandom_range(0, 2000));
        endcase
    endfunction

    // Driver, with random idle bursts between requests
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_reqs.size() > 0 && !pause_sender &&
                         (calm || $urandom_range(0, 5) != 0)) begin
                s_data  <= pending_reqs.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
                if (!calm) gap_left <= $urandom_range(0, 2);
            end
        end
    end

    // Predict on acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_results.insert(expected_results.size(), apply_timer_req(s_data));
    end

    // Receiver ready, with random stalls and one long hold-off
    int stall_left;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (hold_start && !hold_done) begin
            if (hold_rx < HOLD_LEN) begin
                hold_rx <= hold_rx + 1;
                m_ready <= 1'b0;
            end else begin
                hold_done <= 1'b1;
            end
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor
    always @(posedge aclk) begin
        result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_data), 0);
            end else begin
                w = expected_results.pop_front();
                if (m_data.status !== w.status)
                    report_mismatch("status", m_data.status, w.status);
                if (m_data.earliest_valid !== w.earliest_valid)
                    report_mismatch("earliest_valid", m_data.earliest_valid, w.earliest_valid);
                if (m_data.earliest_id !== w.earliest_id)
                    report_mismatch("earliest_id", m_data.earliest_id, w.earliest_id);
                if (m_data.earliest_deadline !== w.earliest_deadline)
                    report_mismatch("earliest_deadline", m_data.earliest_deadline,
                                    w.earliest_deadline);
                if (m_data.entry_count !== w.entry_count)
                    report_mismatch("entry_count", m_data.entry_count, w.entry_count);
            end
        end
    end

    // Timeout guard
    always @(posedge aclk) begin
        if (cycles > LIMIT) begin
            $display("timeout waiting for results");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Queue a well-formed-ish random request against the live id set
    task automatic queue_random(input int add_bias);
        int sel;
        int id;
        int k;
        sel = $urandom_range(0, 99);
        if (live_ids.size() == 0 || sel < add_bias) begin
            id = (live_ids.size() > 0 && $urandom_range(0, 4) == 0) ?
                 live_ids[$urandom_range(0, live_ids.size() - 1)] :
                 $urandom_range(0, IDS - 1);
            queue_req(make_req(OP_ADD, id, rand_now(), rand_tmo()));
            if (live_ids.size() < CAP) begin
                foreach (live_ids[i]) if (live_ids[i] == id) id = -1;
                if (id >= 0) live_ids.insert(live_ids.size(), id);
            end
        end else if (sel < 80) begin
            k = $urandom_range(0, live_ids.size() - 1);
            queue_req(make_req(OP_ADJUST, live_ids[k], rand_now(), rand_tmo()));
        end else if (sel < 95) begin
            k = $urandom_range(0, live_ids.size() - 1);
            queue_req(make_req(OP_REMOVE, live_ids[k], rand_now(), rand_tmo()));
            live_ids.delete(k);
        end else begin
            // noise: absent ids and the unused code
            queue_req(make_req(2'($urandom_range(1, 3)), $urandom_range(0, IDS - 1),
                               $urandom, 31'($urandom)));
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        calm = 0;
        pause_sender = 0;
        hold_start = 0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty heap, extremes, absent ids, unused code, ties, saturation
        queue_req(make_req(OP_ADJUST, 5, 0, 0));
        queue_req(make_req(OP_REMOVE, 1023, 0, 0));
        queue_req(make_req(2'd3, 7, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
        queue_req(make_req(OP_ADD, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
        queue_req(make_req(OP_ADD, 1023, 32'hFFFF_FFFE, 1));
        queue_req(make_req(OP_ADD, 10, 100, 0));
        queue_req(make_req(OP_ADD, 11, 50, 50));
        queue_req(make_req(OP_ADD, 12, 0, 0));
        queue_req(make_req(OP_ADD, 10, 0, 500));
        queue_req(make_req(OP_ADJUST, 12, 32'h8000_0000, 31'h7FFF_FFFF));
        queue_req(make_req(OP_ADJUST, 1023, 0, 1));
        queue_req(make_req(OP_REMOVE, 1023, 0, 0));
        queue_req(make_req(OP_REMOVE, 12, 0, 0));
        queue_req(make_req(OP_REMOVE, 12, 0, 0));
        queue_req(make_req(OP_REMOVE, 0, 0, 0));
        queue_req(make_req(OP_REMOVE, 10, 0, 0));
        queue_req(make_req(OP_REMOVE, 11, 0, 0));
        queue_req(make_req(2'd3, 0, 0, 0));
        drain();

        // Fill to capacity, overflow, then re-arm while full
        for (int i = 0; i < CAP; i++)
            queue_req(make_req(OP_ADD, 100 + i, 1000, 31'($urandom_range(0, 300))));
        queue_req(make_req(OP_ADD, 900, 0, 0));
        queue_req(make_req(OP_ADD, 100, 0, 0));
        // Receiver holds off while the sender keeps offering
        hold_start = 1'b1;
        for (int i = 0; i < CAP; i++)
            queue_req(make_req(OP_REMOVE, 100 + ((i * 37) % CAP), 0, 0));
        drain();

        // Random mix; sender pauses mid-way until all results are in
        for (int n = 0; n < 1550; n++) begin
            queue_random(n < 700 ? 55 : 40);
            if (n == 800) begin
                while (pending_reqs.size() > 0) @(posedge aclk);
                pause_sender = 1;
                while (expected_results.size() > 0 || s_valid) @(posedge aclk);
                pause_sender = 0;
            end
        end
        // Last stretch runs without idling
        while (pending_reqs.size() > 250) @(posedge aclk);
        calm = 1;
        drain();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/imht_pkg.sv
design/imht_ram.sv
design/imht_ctrl.sv
design/imht_dp.sv
design/indexed_min_heap_timer.sv
bench/tb_indexed_min_heap_timer.sv
